// File: rtl/core/bsm_pkg.sv
// Package for the byte stack machine execute stage.
// Opcode and error codes, divider request type. No dependencies.
`timescale 1ns / 1ps
package bsm_pkg;

  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_PUSH  = 5'd1;
  localparam logic [4:0] OP_POP   = 5'd2;
  localparam logic [4:0] OP_ADD   = 5'd3;
  localparam logic [4:0] OP_MUL   = 5'd4;
  localparam logic [4:0] OP_SUB   = 5'd5;
  localparam logic [4:0] OP_DIV   = 5'd6;
  localparam logic [4:0] OP_PRSP  = 5'd7;
  localparam logic [4:0] OP_PRT   = 5'd8;
  localparam logic [4:0] OP_PABS  = 5'd9;
  localparam logic [4:0] OP_LRSP  = 5'd10;
  localparam logic [4:0] OP_LABS  = 5'd11;
  localparam logic [4:0] OP_JMP   = 5'd12;
  localparam logic [4:0] OP_JZ    = 5'd13;
  localparam logic [4:0] OP_JNZ   = 5'd14;
  localparam logic [4:0] OP_CMP   = 5'd15;
  localparam logic [4:0] OP_PRINT = 5'd16;
  localparam logic [4:0] OP_CALL  = 5'd17;
  localparam logic [4:0] OP_ENTER = 5'd18;
  localparam logic [4:0] OP_RET   = 5'd19;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_NOOPND = 3'd1;
  localparam logic [2:0] ERR_RANGE  = 3'd2;
  localparam logic [2:0] ERR_DIVZ   = 3'd3;
  localparam logic [2:0] ERR_OVFL   = 3'd4;
  localparam logic [2:0] ERR_UNFL   = 3'd5;
  localparam logic [2:0] ERR_BADOP  = 3'd6;

  localparam logic [1:0] FLAG_NE    = 2'd0;
  localparam logic [1:0] FLAG_EQ    = 2'd1;
  localparam logic [1:0] FLAG_RESET = 2'd2;

  typedef struct packed {
    logic       start;
    logic [7:0] num;
    logic [7:0] den;
  } bsm_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quo;
  } bsm_div_rsp_t;

endpackage

// File: rtl/core/bsm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: rtl/core/bsm_div.sv
// Restoring 8-bit divider, one quotient bit per cycle.
// Depends on bsm_pkg for the request and response types.
`timescale 1ns / 1ps
module bsm_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsm_pkg::bsm_div_req_t req,
  output bsm_pkg::bsm_div_rsp_t rsp
);
  import bsm_pkg::*;

  logic       busy_r;
  logic       done_r;
  logic [2:0] cnt_r;
  logic [7:0] rem_r;
  logic [7:0] quo_r;
  logic [7:0] den_r;
  logic [8:0] shl;
  logic [8:0] dif;

  assign shl = {rem_r, quo_r[7]};
  assign dif = shl - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 3'd7);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
        rem_r  <= 8'd0;
        quo_r  <= req.num;
        den_r  <= req.den;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (!dif[8]) begin
          rem_r <= dif[7:0];
          quo_r <= {quo_r[6:0], 1'b1};
        end else begin
          rem_r <= shl[7:0];
          quo_r <= {quo_r[6:0], 1'b0};
        end
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.start && busy_r)) else $error("divider started while busy");

endmodule

// File: rtl/core/byte_stack_machine_execute.sv
// Execute stage of a byte stack machine: sequencer around one stack RAM.
// Depends on bsm_pkg, bsm_ram and bsm_div.
`timescale 1ns / 1ps
// One instruction is taken at a time. Each stack byte read passes through a
// read state (S_RD) and a capture state (S_CAP) on the single read port of
// the stack RAM; divide also waits for the bit-serial divider, and enter
// copies each byte through S_ECRD and S_ECWR. Results leave through an
// output register, so the next instruction is accepted while a result waits.
// Stack entries never written read as zero through one valid flag per entry.
// After an error the block answers every instruction with the latched error
// until reset.
module byte_stack_machine_execute #(
  parameter int STACK_DEPTH  = 256,
  parameter int JUMP_ENTRIES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_opcode,
  input  logic       in_operand_present,
  input  logic [7:0] in_operand_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_next_pc,
  output logic       out_print_valid,
  output logic [7:0] out_print_value,
  output logic [2:0] out_error_code,
  output logic       out_halted,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import bsm_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_RD    = 10'b0000000100,
    S_CAP   = 10'b0000001000,
    S_EXEC  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_WR    = 10'b0001000000,
    S_ECRD  = 10'b0010000000,
    S_ECWR  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r;

  logic [7:0]        jt_r [8];
  logic signed [8:0] t_r;
  logic [7:0]        sp_r;
  logic [7:0]        pc_r;
  logic [1:0]        flag_r;
  logic              stop_r;
  logic [2:0]        lat_r;

  logic [4:0]        op_r;
  logic              has_r;
  logic [7:0]        d_r;
  logic [2:0]        err_r;
  logic [7:0]        rdat_r [4];
  logic [1:0]        rcnt_r;
  logic [1:0]        wcnt_r;
  logic [7:0]        ecnt_r;
  logic [7:0]        res_r;
  logic signed [8:0] nt_r;
  logic [7:0]        nsp_r;
  logic [7:0]        npc_r;
  logic [1:0]        nflag_r;
  logic              npv_r;
  logic [7:0]        npval_r;

  logic              out_valid_r;
  logic [7:0]        out_pc_r;
  logic              out_pv_r;
  logic [7:0]        out_pval_r;
  logic [2:0]        out_err_r;
  logic              out_halt_r;

  logic [STACK_DEPTH-1:0] wvld_r;
  logic              vld_q_r;

  logic signed [10:0] t_s, sp_s, d_s, dep_s;
  logic signed [10:0] rd_a, wr_a;
  logic [7:0]        wr_d;
  logic              re, we;
  logic [7:0]        ram_q, rdm;
  logic [2:0]        chk_err;
  logic [2:0]        nrd, nwr;
  logic              lbl_ok;
  logic [7:0]        lbl_m1;
  logic [7:0]        tgt;
  logic              jcond;
  logic [15:0]       prod;
  logic              out_free;

  bsm_div_req_t      dreq;
  bsm_div_rsp_t      drsp;

  assign t_s   = {{2{t_r[8]}}, t_r};
  assign sp_s  = {3'b000, sp_r};
  assign d_s   = {3'b000, d_r};
  assign dep_s = 11'(STACK_DEPTH);

  assign lbl_m1 = d_r - 8'd1;
  assign lbl_ok = (d_r != 8'd0) && (int'(d_r) <= JUMP_ENTRIES);
  assign tgt    = jt_r[lbl_m1[2:0]];
  assign jcond  = (op_r == OP_JMP) || (op_r == OP_JZ && flag_r == FLAG_NE) ||
                  (op_r == OP_JNZ && flag_r == FLAG_EQ);

  // checks that need no stack data
  always_comb begin
    chk_err = ERR_NONE;
    unique case (op_r)
      OP_NOP, OP_PABS, OP_LABS: chk_err = ERR_NONE;
      OP_PUSH: begin
        if (!has_r) chk_err = ERR_NOOPND;
        else if (t_s + 11'sd1 >= dep_s) chk_err = ERR_OVFL;
      end
      OP_POP, OP_PRINT: begin
        if (t_s < 11'sd0) chk_err = ERR_UNFL;
      end
      OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_CMP: begin
        if (t_s < 11'sd1) chk_err = ERR_UNFL;
      end
      OP_PRSP, OP_PRT: begin
        if (!has_r) chk_err = ERR_NOOPND;
        else if ((op_r == OP_PRSP) ? (sp_s + d_s > t_s) : (t_s - d_s < sp_s))
          chk_err = ERR_RANGE;
        else if (t_s + 11'sd1 >= dep_s) chk_err = ERR_OVFL;
      end
      OP_LRSP: begin
        if (!has_r) chk_err = ERR_NOOPND;
        else if (t_s < 11'sd0) chk_err = ERR_UNFL;
        else if (sp_s + d_s >= dep_s) chk_err = ERR_RANGE;
      end
      OP_JMP, OP_JZ, OP_JNZ: begin
        if (jcond) begin
          if (!has_r) chk_err = ERR_NOOPND;
          else if (!lbl_ok) chk_err = ERR_RANGE;
        end
      end
      OP_CALL: begin
        if (!has_r) chk_err = ERR_NOOPND;
        else if (!lbl_ok) chk_err = ERR_RANGE;
        else if (t_s + 11'sd4 >= dep_s) chk_err = ERR_OVFL;
      end
      OP_ENTER: begin
        if (!has_r) chk_err = ERR_NOOPND;
        else if ((sp_s - 11'sd3 - d_s < 11'sd0) || (sp_s - 11'sd3 > dep_s))
          chk_err = ERR_RANGE;
        else if (t_s + d_s >= dep_s) chk_err = ERR_OVFL;
      end
      OP_RET: begin
        if ((sp_s < 11'sd3) || (sp_s > dep_s)) chk_err = ERR_RANGE;
        else if (t_s < 11'sd0) chk_err = ERR_UNFL;
      end
      default: chk_err = ERR_BADOP;
    endcase
  end

  always_comb begin
    nrd = 3'd0;
    nwr = 3'd0;
    case (op_r)
      OP_ADD, OP_MUL, OP_SUB, OP_DIV: begin
        nrd = 3'd2;
        nwr = 3'd1;
      end
      OP_CMP: nrd = 3'd2;
      OP_PRINT: nrd = 3'd1;
      OP_PRSP, OP_PRT, OP_LRSP: begin
        nrd = 3'd1;
        nwr = 3'd1;
      end
      OP_PUSH: nwr = 3'd1;
      OP_CALL: nwr = 3'd3;
      OP_RET: begin
        nrd = 3'd4;
        nwr = 3'd1;
      end
      default: begin
        nrd = 3'd0;
        nwr = 3'd0;
      end
    endcase
  end

  always_comb begin
    rd_a = t_s;
    if (state_r == S_ECRD) begin
      rd_a = sp_s - 11'sd3 - d_s + {3'b000, ecnt_r};
    end else begin
      case (op_r)
        OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_CMP:
          rd_a = (rcnt_r == 2'd0) ? t_s : t_s - 11'sd1;
        OP_PRSP: rd_a = sp_s + d_s;
        OP_PRT:  rd_a = t_s - d_s;
        OP_RET: begin
          case (rcnt_r)
            2'd0:    rd_a = sp_s - 11'sd3;
            2'd1:    rd_a = sp_s - 11'sd2;
            2'd2:    rd_a = sp_s - 11'sd1;
            default: rd_a = t_s;
          endcase
        end
        default: rd_a = t_s;
      endcase
    end
  end

  always_comb begin
    wr_a = t_s + 11'sd1;
    wr_d = d_r;
    if (state_r == S_ECWR) begin
      wr_a = t_s + 11'sd1 + {3'b000, ecnt_r};
      wr_d = rdm;
    end else begin
      case (op_r)
        OP_ADD, OP_MUL, OP_SUB, OP_DIV: begin
          wr_a = t_s - 11'sd1;
          wr_d = res_r;
        end
        OP_PRSP, OP_PRT: wr_d = rdat_r[0];
        OP_LRSP: begin
          wr_a = sp_s + d_s;
          wr_d = rdat_r[0];
        end
        OP_CALL: begin
          case (wcnt_r)
            2'd0: begin
              wr_a = t_s + 11'sd1;
              wr_d = t_r[7:0];
            end
            2'd1: begin
              wr_a = t_s + 11'sd2;
              wr_d = sp_r;
            end
            default: begin
              wr_a = t_s + 11'sd3;
              wr_d = pc_r;
            end
          endcase
        end
        OP_RET: begin
          wr_a = {3'b000, rdat_r[0]} + 11'sd1;
          wr_d = rdat_r[3];
        end
        default: begin
          wr_a = t_s + 11'sd1;
          wr_d = d_r;
        end
      endcase
    end
  end

  assign re   = (state_r == S_RD) || (state_r == S_ECRD);
  assign we   = (state_r == S_WR) || (state_r == S_ECWR);
  assign rdm  = vld_q_r ? ram_q : 8'd0;
  assign prod = rdat_r[0] * rdat_r[1];
  assign out_free = !out_valid_r || !out_stall;

  assign dreq.start = (state_r == S_EXEC) && (op_r == OP_DIV) && (rdat_r[0] != 8'd0);
  assign dreq.num   = rdat_r[1];
  assign dreq.den   = rdat_r[0];

  bsm_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (wr_a[AW-1:0]),
    .wdata (wr_d),
    .re    (re),
    .raddr (rd_a[AW-1:0]),
    .rdata (ram_q)
  );

  bsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) jt_r[i] <= 8'd0;
    end else if (cfg_we) begin
      jt_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
    end else if (we) begin
      wvld_r[wr_a[AW-1:0]] <= 1'b1;
    end
    if (re) begin
      vld_q_r <= wvld_r[rd_a[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      t_r         <= -9'sd1;
      sp_r        <= 8'd0;
      pc_r        <= 8'd0;
      flag_r      <= FLAG_RESET;
      stop_r      <= 1'b0;
      lat_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            has_r   <= in_operand_present;
            d_r     <= in_operand_byte;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          nt_r    <= t_r;
          nsp_r   <= sp_r;
          npc_r   <= pc_r + 8'd1;
          nflag_r <= flag_r;
          npv_r   <= 1'b0;
          npval_r <= 8'd0;
          rcnt_r  <= 2'd0;
          wcnt_r  <= 2'd0;
          ecnt_r  <= 8'd0;
          if (stop_r) begin
            err_r   <= lat_r;
            state_r <= S_FIN;
          end else begin
            err_r   <= chk_err;
            if (chk_err != ERR_NONE) state_r <= S_FIN;
            else if (nrd != 3'd0)    state_r <= S_RD;
            else                     state_r <= S_EXEC;
          end
        end
        S_RD: state_r <= S_CAP;
        S_CAP: begin
          rdat_r[rcnt_r] <= rdm;
          rcnt_r <= rcnt_r + 2'd1;
          if ({1'b0, rcnt_r} + 3'd1 == nrd) state_r <= S_EXEC;
          else                              state_r <= S_RD;
        end
        S_EXEC: begin
          case (op_r)
            OP_PUSH, OP_PRSP, OP_PRT: begin
              nt_r    <= t_r + 9'sd1;
              state_r <= S_WR;
            end
            OP_POP: begin
              nt_r    <= t_r - 9'sd1;
              state_r <= S_FIN;
            end
            OP_LRSP: begin
              nt_r    <= t_r - 9'sd1;
              state_r <= S_WR;
            end
            OP_ADD: begin
              res_r   <= rdat_r[0] + rdat_r[1];
              nt_r    <= t_r - 9'sd1;
              state_r <= S_WR;
            end
            OP_MUL: begin
              res_r   <= prod[7:0];
              nt_r    <= t_r - 9'sd1;
              state_r <= S_WR;
            end
            OP_SUB: begin
              res_r   <= rdat_r[1] - rdat_r[0];
              nt_r    <= t_r - 9'sd1;
              state_r <= S_WR;
            end
            OP_DIV: begin
              nt_r <= t_r - 9'sd1;
              if (rdat_r[0] == 8'd0) begin
                err_r   <= ERR_DIVZ;
                state_r <= S_FIN;
              end else begin
                state_r <= S_DIV;
              end
            end
            OP_CMP: begin
              nflag_r <= (rdat_r[0] == rdat_r[1]) ? FLAG_EQ : FLAG_NE;
              state_r <= S_FIN;
            end
            OP_PRINT: begin
              npv_r   <= 1'b1;
              npval_r <= rdat_r[0];
              state_r <= S_FIN;
            end
            OP_JMP, OP_JZ, OP_JNZ: begin
              if (jcond) npc_r <= tgt;
              state_r <= S_FIN;
            end
            OP_CALL: begin
              nt_r    <= t_r + 9'sd3;
              nsp_r   <= t_r[7:0] + 8'd4;
              npc_r   <= tgt;
              state_r <= S_WR;
            end
            OP_ENTER: begin
              nt_r    <= t_r + $signed({1'b0, d_r});
              state_r <= (d_r == 8'd0) ? S_FIN : S_ECRD;
            end
            OP_RET: begin
              if ({3'b000, rdat_r[0]} + 11'sd1 >= dep_s) begin
                err_r   <= ERR_OVFL;
                state_r <= S_FIN;
              end else begin
                nt_r    <= $signed({1'b0, rdat_r[0]}) + 9'sd1;
                nsp_r   <= rdat_r[1];
                npc_r   <= rdat_r[2] + 8'd1;
                state_r <= S_WR;
              end
            end
            default: begin
              nt_r    <= t_r;
              state_r <= S_FIN;
            end
          endcase
        end
        S_DIV: begin
          if (drsp.done) begin
            res_r   <= drsp.quo;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          wcnt_r <= wcnt_r + 2'd1;
          if ({1'b0, wcnt_r} + 3'd1 == nwr) state_r <= S_FIN;
        end
        S_ECRD: state_r <= S_ECWR;
        S_ECWR: begin
          ecnt_r <= ecnt_r + 8'd1;
          state_r <= (ecnt_r + 8'd1 == d_r) ? S_FIN : S_ECRD;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (err_r != ERR_NONE) begin
              stop_r     <= 1'b1;
              lat_r      <= err_r;
              out_pc_r   <= pc_r;
              out_pv_r   <= 1'b0;
              out_pval_r <= 8'd0;
              out_err_r  <= err_r;
              out_halt_r <= 1'b1;
            end else begin
              t_r        <= nt_r;
              sp_r       <= nsp_r;
              pc_r       <= npc_r;
              flag_r     <= nflag_r;
              out_pc_r   <= npc_r;
              out_pv_r   <= npv_r;
              out_pval_r <= npval_r;
              out_err_r  <= ERR_NONE;
              out_halt_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_print_valid = out_pv_r;
  assign out_print_value = out_pval_r;
  assign out_error_code  = out_err_r;
  assign out_halted      = out_halt_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r) else $error("halt cleared without reset");

  a_halt_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_halt_r) |-> (out_err_r != ERR_NONE))
    else $error("halted result without error code");

  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(stop_r) && stop_r) |-> !we) else $error("stack written while halted");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed({{2{t_r[8]}}, t_r}) < 11'(STACK_DEPTH)))
    else $error("top index beyond stack");

endmodule

// File: bench/tb_byte_stack_machine_execute.sv
// Self-checking testbench for byte_stack_machine_execute: directed table, then
// constrained-by-retry random instructions checked against a local predictor.
// Depends on bsm_pkg and the execute stage RTL.
`timescale 1ns / 1ps
module tb_byte_stack_machine_execute;
  import bsm_pkg::*;

  localparam int DEPTH = 256;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [7:0] pc;
    logic       pv;
    logic [7:0] pval;
    logic [2:0] err;
    logic       halt;
  } exec_res_t;

  typedef struct {
    logic [4:0] op;
    bit         has;
    logic [7:0] d;
    bit         typed;
    int         pc;
    logic [2:0] err;
    bit         halt;
  } insn_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [4:0] in_opcode;
  logic       in_operand_present;
  logic [7:0] in_operand_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_next_pc;
  logic       out_print_valid;
  logic [7:0] out_print_value;
  logic [2:0] out_error_code;
  logic       out_halted;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  byte_stack_machine_execute dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_operand_present(in_operand_present),
    .in_operand_byte(in_operand_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_next_pc(out_next_pc), .out_print_valid(out_print_valid),
    .out_print_value(out_print_value), .out_error_code(out_error_code),
    .out_halted(out_halted),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // machine state mirror
  logic [7:0] st_mem [DEPTH];
  int         st_top;
  int         st_fb;
  int         st_pc;
  logic [1:0] st_flag;
  bit         st_halt;
  logic [2:0] st_lerr;
  logic [7:0] jump_tab [8];

  exec_res_t  pending_q [$];
  int         errors;
  int         quiet_cycles;
  bit         idle_en;
  bit         long_hold;

  function automatic exec_res_t run_insn(input logic [4:0] op, input bit has,
                                         input logic [7:0] dbyte, input bit commit);
    exec_res_t  r;
    logic [7:0] m [DEPTH];
    int         t, sp, d, npc, tgt, addr, ot, os, opc, a, b, q, i;
    logic [7:0] rv;
    logic [2:0] err;
    logic [1:0] fl;
    bit         cond;
    m = st_mem;
    t = st_top;
    sp = st_fb;
    d = dbyte;
    npc = (st_pc + 1) & 255;
    err = ERR_NONE;
    fl = st_flag;
    tgt = 0;
    r = '0;
    r.pc = st_pc[7:0];
    if (st_halt) begin
      r.err = st_lerr;
      r.halt = 1'b1;
      return r;
    end
    case (op)
      OP_NOP, OP_PABS, OP_LABS: ;
      OP_PUSH: begin
        if (!has) err = ERR_NOOPND;
        else if (t + 1 >= DEPTH) err = ERR_OVFL;
        else begin
          t++;
          m[t] = dbyte;
        end
      end
      OP_POP: begin
        if (t < 0) err = ERR_UNFL;
        else t--;
      end
      OP_ADD, OP_MUL, OP_SUB, OP_DIV: begin
        if (t < 1) err = ERR_UNFL;
        else begin
          a = m[t];
          b = m[t-1];
          if (op == OP_DIV && a == 0) err = ERR_DIVZ;
          else begin
            case (op)
              OP_ADD: q = a + b;
              OP_MUL: q = a * b;
              OP_SUB: q = b - a;
              default: q = b / a;
            endcase
            m[t-1] = q[7:0];
            t--;
          end
        end
      end
      OP_PRSP, OP_PRT: begin
        addr = (op == OP_PRSP) ? sp + d : t - d;
        if (!has) err = ERR_NOOPND;
        else if ((op == OP_PRSP) ? addr > t : addr < sp) err = ERR_RANGE;
        else if (t + 1 >= DEPTH) err = ERR_OVFL;
        else begin
          m[t+1] = m[addr];
          t++;
        end
      end
      OP_LRSP: begin
        if (!has) err = ERR_NOOPND;
        else if (t < 0) err = ERR_UNFL;
        else if (sp + d >= DEPTH) err = ERR_RANGE;
        else begin
          rv = m[t];
          t--;
          m[sp+d] = rv;
        end
      end
      OP_JMP, OP_JZ, OP_JNZ: begin
        cond = (op == OP_JMP) || (op == OP_JZ && fl == FLAG_NE) ||
               (op == OP_JNZ && fl == FLAG_EQ);
        if (cond) begin
          if (!has) err = ERR_NOOPND;
          else if (d < 1 || d > 8) err = ERR_RANGE;
          else npc = jump_tab[d-1];
        end
      end
      OP_CMP: begin
        if (t < 1) err = ERR_UNFL;
        else fl = (m[t] == m[t-1]) ? FLAG_EQ : FLAG_NE;
      end
      OP_PRINT: begin
        if (t < 0) err = ERR_UNFL;
        else begin
          r.pv = 1'b1;
          r.pval = m[t];
        end
      end
      OP_CALL: begin
        if (!has) err = ERR_NOOPND;
        else if (d < 1 || d > 8) err = ERR_RANGE;
        else if (t + 4 >= DEPTH) err = ERR_OVFL;
        else begin
          tgt = jump_tab[d-1];
          m[t+1] = t[7:0];
          m[t+2] = sp[7:0];
          m[t+3] = st_pc[7:0];
          t += 3;
          sp = t + 1;
          npc = tgt;
        end
      end
      OP_ENTER: begin
        if (!has) err = ERR_NOOPND;
        else if (sp - 3 - d < 0 || sp - 3 > DEPTH) err = ERR_RANGE;
        else if (t + d >= DEPTH) err = ERR_OVFL;
        else begin
          for (i = 0; i < d; i++) begin
            m[t+1] = m[sp-3-d+i];
            t++;
          end
        end
      end
      OP_RET: begin
        if (sp < 3 || sp > DEPTH) err = ERR_RANGE;
        else if (t < 0) err = ERR_UNFL;
        else begin
          ot = m[sp-3];
          os = m[sp-2];
          opc = m[sp-1];
          rv = m[t];
          if (ot + 1 >= DEPTH) err = ERR_OVFL;
          else begin
            sp = os;
            t = ot + 1;
            m[t] = rv;
            npc = (opc + 1) & 255;
          end
        end
      end
      default: err = ERR_BADOP;
    endcase
    if (err != ERR_NONE) begin
      if (commit) begin
        st_halt = 1'b1;
        st_lerr = err;
      end
      r.pv = 1'b0;
      r.pval = '0;
      r.err = err;
      r.halt = 1'b1;
      return r;
    end
    if (commit) begin
      st_mem = m;
      st_top = t;
      st_fb = sp & 255;
      st_pc = npc;
      st_flag = fl;
    end
    r.pc = npc[7:0];
    return r;
  endfunction

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) quiet_cycles <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    exec_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected transaction pc=%0d", $realtime, out_next_pc);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_next_pc !== e.pc || out_print_valid !== e.pv ||
            out_print_value !== e.pval || out_error_code !== e.err ||
            out_halted !== e.halt) begin
          $display("%0t mismatch exp pc=%0d pv=%0b pval=%0d err=%0d halt=%0b",
                   $realtime, e.pc, e.pv, e.pval, e.err, e.halt);
          $display("%0t          got pc=%0d pv=%0b pval=%0d err=%0d halt=%0b",
                   $realtime, out_next_pc, out_print_valid, out_print_value,
                   out_error_code, out_halted);
          errors++;
        end
      end
    end
  end

  // receiver: random hold-off bursts, plus one long hold on request
  initial begin
    bit long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !long_done) begin
        long_done = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_insn(input logic [4:0] op, input bit has, input logic [7:0] d,
                           input bit typed, input int tpc, input logic [2:0] terr,
                           input bit thalt);
    exec_res_t p;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_opcode = op;
    in_operand_present = has;
    in_operand_byte = d;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    p = run_insn(op, has, d, 1'b1);
    if (typed) begin
      if (tpc >= 0) p.pc = tpc[7:0];
      p.err = terr;
      p.halt = thalt;
    end
    pending_q.push_back(p);
  endtask

  task automatic send_random;
    logic [4:0] op;
    bit         has;
    logic [7:0] d;
    exec_res_t  r;
    int         span;
    do begin
      op = 5'($urandom_range(OP_NOP, OP_RET));
      has = ($urandom_range(0, 15) != 0);
      span = st_top - st_fb;
      case (op)
        OP_PRSP, OP_PRT: d = (span >= 0) ? 8'($urandom_range(0, span)) : 8'd0;
        OP_LRSP: d = 8'($urandom_range(0, 255 - st_fb));
        OP_JMP, OP_JZ, OP_JNZ, OP_CALL: d = 8'($urandom_range(1, 8));
        OP_ENTER: d = 8'($urandom_range(0, 3));
        default: d = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 7) == 0) d = 8'($urandom_range(0, 255));
      r = run_insn(op, has, d, 1'b0);
    end while (r.err != ERR_NONE);
    send_insn(op, has, d, 1'b0, -1, ERR_NONE, 1'b0);
  endtask

  task automatic drain_and_wait;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mode 0: extremes by index, 1: all ones, 2: all zeros, else random
  task automatic load_jump_table(input int mode);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'(i * 37);
        1: v = 8'd255;
        2: v = 8'd0;
        default: v = 8'($urandom_range(0, 255));
      endcase
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = i[2:0];
      cfg_data = v;
      jump_tab[i] = v;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  insn_row_t opening [] = '{
    '{OP_NOP,   0, 8'd0,   1, 1,  ERR_NONE, 0},
    '{OP_PUSH,  1, 8'd255, 0, -1, ERR_NONE, 0},
    '{OP_PUSH,  1, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_ADD,   0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_PUSH,  1, 8'd255, 0, -1, ERR_NONE, 0},
    '{OP_MUL,   0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_PUSH,  1, 8'd128, 0, -1, ERR_NONE, 0},
    '{OP_SUB,   1, 8'd255, 0, -1, ERR_NONE, 0},
    '{OP_PUSH,  1, 8'd7,   0, -1, ERR_NONE, 0},
    '{OP_DIV,   0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_PUSH,  1, 8'd18,  0, -1, ERR_NONE, 0},
    '{OP_CMP,   0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_JZ,    0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_JNZ,   1, 8'd2,   0, -1, ERR_NONE, 0},
    '{OP_PRINT, 0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_PRSP,  1, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_PRT,   1, 8'd2,   0, -1, ERR_NONE, 0},
    '{OP_LRSP,  1, 8'd5,   0, -1, ERR_NONE, 0},
    '{OP_PABS,  0, 8'd170, 0, -1, ERR_NONE, 0},
    '{OP_LABS,  1, 8'd85,  0, -1, ERR_NONE, 0},
    '{OP_CALL,  1, 8'd1,   0, -1, ERR_NONE, 0},
    '{OP_ENTER, 1, 8'd2,   0, -1, ERR_NONE, 0},
    '{OP_RET,   0, 8'd0,   0, -1, ERR_NONE, 0},
    '{OP_JMP,   1, 8'd8,   0, -1, ERR_NONE, 0}
  };

  insn_row_t closing [] = '{
    '{5'd31,    1, 8'd255, 1, -1, ERR_BADOP, 1},
    '{OP_NOP,   0, 8'd0,   1, -1, ERR_BADOP, 1},
    '{OP_PUSH,  1, 8'd1,   1, -1, ERR_BADOP, 1}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_NOP;
    in_operand_present = 1'b0;
    in_operand_byte = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_en = 1'b1;
    long_hold = 1'b0;
    foreach (st_mem[i]) st_mem[i] = '0;
    foreach (jump_tab[i]) jump_tab[i] = '0;
    st_top = -1;
    st_fb = 0;
    st_pc = 0;
    st_flag = FLAG_RESET;
    st_halt = 1'b0;
    st_lerr = ERR_NONE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load_jump_table(0);
    foreach (opening[i])
      send_insn(opening[i].op, opening[i].has, opening[i].d, opening[i].typed,
                opening[i].pc, opening[i].err, opening[i].halt);
    drain_and_wait();

    for (int ph = 1; ph <= 4; ph++) begin
      load_jump_table(ph);
      if (ph == 2) long_hold = 1'b1;
      if (ph == 4) idle_en = 1'b0;
      repeat (150) send_random();
      drain_and_wait();
    end

    foreach (closing[i])
      send_insn(closing[i].op, closing[i].has, closing[i].d, closing[i].typed,
                closing[i].pc, closing[i].err, closing[i].halt);
    drain_and_wait();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: byte_stack_machine_execute.f
rtl/core/bsm_pkg.sv
rtl/core/bsm_ram.sv
rtl/core/bsm_div.sv
rtl/core/byte_stack_machine_execute.sv
bench/tb_byte_stack_machine_execute.sv
